/* sv/skl_pkg.sv */
`timescale 1ns / 1ps

package skl_pkg;

    localparam int DATA_W = 32;
    localparam int KEEP_W = 5;

    typedef logic signed [DATA_W-1:0] t_value;
    typedef logic [KEEP_W-1:0]        t_keep;

    // per-transaction cell controls; load and clear are broadcast along the cell row
    typedef struct packed {
        logic load;
        logic clear;
        logic in_range;
    } t_cell_ctrl;

endpackage

/* sv/skl_cell.sv */
`timescale 1ns / 1ps

module skl_cell #(
    parameter bit IS_FRONT = 1'b0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  skl_pkg::t_cell_ctrl i_ctrl,
    input  skl_pkg::t_value     i_sample,
    input  logic                i_move_in,
    input  skl_pkg::t_value     i_up_value,
    input  logic                i_up_move,
    output logic                o_move,
    output skl_pkg::t_value     o_value,
    output skl_pkg::t_value     o_new_value
);
    import skl_pkg::*;

    t_value r_value;
    t_value n_value;
    logic   w_take;

    // front entry is replaced only by a strictly greater value;
    // further up the value keeps moving past equal entries
    always_comb begin
        if (IS_FRONT) begin
            w_take = r_value < i_sample;
        end else begin
            w_take = r_value <= i_sample;
        end
    end

    assign o_move = i_move_in && i_ctrl.in_range && w_take;

    always_comb begin
        if (i_up_move) begin
            o_new_value = i_up_value;
        end else if (o_move) begin
            o_new_value = i_sample;
        end else begin
            o_new_value = r_value;
        end
    end

    always_comb begin
        n_value = r_value;
        if (i_ctrl.load) begin
            if (i_ctrl.clear) begin
                n_value = '0;
            end else begin
                n_value = o_new_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

/* sv/streaming_kth_largest.sv */
`timescale 1ns / 1ps
// Streaming k-th largest value.
// Input channel: i_in_valid / o_in_stall carry i_sample_value and i_is_last.
// Output channel: o_out_valid / i_out_stall carry o_kth_largest.
// A transaction is taken when valid is high and stall is low.
// i_cfg_we / i_cfg_data write k (keep count); write only while idle.
// k = 0 acts as 1, k above MAX_KEEP acts as MAX_KEEP.
// Each value is inserted into a row of MAX_KEEP sorted cells; one input
// transaction per cycle is sustained while o_in_stall is low. The cell row
// compares all entries in parallel and shifts them by one place at once.
// On a transaction marked last, the k-th largest value, that value included,
// is registered on the output; the row is cleared to zero in the same edge.
// Values that are zero or negative never enter; too few gives 0.
// While the output is stalled with a result pending, o_in_stall is high.
// Reset clears the row to zero, sets k to 1 and empties the output register.
module streaming_kth_largest #(
    parameter int MAX_KEEP = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  skl_pkg::t_value     i_sample_value,
    input  logic                i_is_last,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output skl_pkg::t_value     o_kth_largest,
    input  logic                i_cfg_we,
    input  skl_pkg::t_keep      i_cfg_data
);
    import skl_pkg::*;

    localparam int IDX_W = $clog2(MAX_KEEP + 1);
    localparam int CNT_W = (IDX_W > KEEP_W) ? IDX_W : KEEP_W;

    t_keep               r_keep_count;
    logic                r_out_valid;
    t_value              r_kth;
    logic                w_accept;
    logic [CNT_W-1:0]    w_keep_ext;
    logic [CNT_W-1:0]    w_k_act;
    t_cell_ctrl          w_ctrl [MAX_KEEP];
    t_value              w_value [MAX_KEEP];
    t_value              w_new [MAX_KEEP];
    logic                w_move [MAX_KEEP];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_keep_ext = CNT_W'(r_keep_count);

    always_comb begin
        if (w_keep_ext == '0) begin
            w_k_act = CNT_W'(1);
        end else if (w_keep_ext > CNT_W'(MAX_KEEP)) begin
            w_k_act = CNT_W'(MAX_KEEP);
        end else begin
            w_k_act = w_keep_ext;
        end
    end

    for (genvar j = 0; j < MAX_KEEP; j++) begin : g_cell
        logic   w_move_in;
        logic   w_up_move;
        t_value w_up_value;

        assign w_ctrl[j].load     = w_accept;
        assign w_ctrl[j].clear    = i_is_last;
        assign w_ctrl[j].in_range = CNT_W'(j) < w_k_act;

        if (j == 0) begin : g_front
            assign w_move_in = 1'b1;
        end else begin : g_body
            assign w_move_in = w_move[j-1];
        end

        if (j == MAX_KEEP - 1) begin : g_top
            assign w_up_move  = 1'b0;
            assign w_up_value = '0;
        end else begin : g_mid
            assign w_up_move  = w_move[j+1];
            assign w_up_value = w_value[j+1];
        end

        skl_cell #(
            .IS_FRONT (j == 0)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl[j]),
            .i_sample    (i_sample_value),
            .i_move_in   (w_move_in),
            .i_up_value  (w_up_value),
            .i_up_move   (w_up_move),
            .o_move      (w_move[j]),
            .o_value     (w_value[j]),
            .o_new_value (w_new[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_count <= t_keep'(1);
        end else if (i_cfg_we) begin
            r_keep_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && i_is_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_is_last) begin
            r_kth <= w_new[0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kth_largest = r_kth;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_is_last) |=> (w_value[0] == '0))
        else $error("front entry not cleared after last transaction");

    a_front_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_value[0][DATA_W-1])
        else $error("front entry negative");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_accept && i_is_last))
        else $error("result without a last transaction");

    a_result_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_kth_largest[DATA_W-1])
        else $error("negative result");

endmodule

/* verif/streaming_kth_largest_tb.sv */
`timescale 1ns / 1ps

module streaming_kth_largest_tb;

    import skl_pkg::*;

    localparam int KEEP_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT  = 5000;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_stall;
    t_value i_sample_value;
    logic   i_is_last;
    logic   o_out_valid;
    logic   i_out_stall;
    t_value o_kth_largest;
    logic   i_cfg_we;
    t_keep  i_cfg_data;

    streaming_kth_largest #(
        .MAX_KEEP(KEEP_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .i_is_last      (i_is_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kth_largest  (o_kth_largest),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    t_value kth_store [KEEP_DEPTH];
    t_keep  keep_reg;
    t_value pending_kth [$];

    int fail_count      = 0;
    int samples_sent    = 0;
    int results_checked = 0;
    int keep_writes     = 0;

    typedef struct packed {
        logic   set_keep;
        t_keep  keep;
        t_value value;
        logic   last;
        logic   typed;
        t_value want;
    } t_row;

    localparam int DIRECTED_ROWS = 21;

    t_row directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, 5'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{1'b0, 5'd0,  32'h8000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{1'b0, 5'd0,  32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{1'b0, 5'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
        '{1'b0, 5'd0,  32'd7,         1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  32'd3,         1'b1, 1'b0, 32'h0000_0000},
        '{1'b1, 5'd16, 32'd100,       1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  32'd50,        1'b1, 1'b1, 32'h0000_0000},
        '{1'b1, 5'd0,  32'd9,         1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  32'd4,         1'b1, 1'b0, 32'h0000_0000},
        '{1'b1, 5'd31, 32'd1,         1'b1, 1'b1, 32'h0000_0000},
        '{1'b1, 5'd2,  32'd10,        1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  32'd10,        1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  32'd5,         1'b1, 1'b0, 32'h0000_0000},
        '{1'b1, 5'd3,  32'd20,        1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  32'd30,        1'b0, 1'b0, 32'h0000_0000},
        '{1'b1, 5'd1,  32'd40,        1'b1, 1'b0, 32'h0000_0000},
        '{1'b1, 5'd2,  32'd1,         1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  32'd2,         1'b1, 1'b1, 32'h0000_0000 + 32'd1},
        '{1'b1, 5'd17, 32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000}
    };

    function automatic int unsigned live_keep();
        if (keep_reg == 0) begin
            return 1;
        end
        if (keep_reg > KEEP_DEPTH) begin
            return KEEP_DEPTH;
        end
        return keep_reg;
    endfunction

    // inserts one value, returns the front entry and clears on last
    function automatic t_value absorb_sample(input t_value v, input logic last);
        int unsigned k;
        t_value      swap_tmp;
        t_value      front;
        k = live_keep();
        if (v > kth_store[0]) begin
            kth_store[0] = v;
            for (int i = 0; i + 1 < k; i++) begin
                if (kth_store[i] < kth_store[i+1]) begin
                    break;
                end
                swap_tmp       = kth_store[i];
                kth_store[i]   = kth_store[i+1];
                kth_store[i+1] = swap_tmp;
            end
        end
        front = kth_store[0];
        if (last) begin
            foreach (kth_store[i]) kth_store[i] = '0;
        end
        return front;
    endfunction

    task automatic write_keep(input t_keep k);
        i_in_valid <= 1'b0;
        while (pending_kth.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= k;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        keep_reg = k;
        keep_writes++;
    endtask

    task automatic offer(input t_value v, input logic last, input logic typed,
                         input t_value want);
        t_value front;
        while (!(samples_sent >= 700 && samples_sent < 1000) &&
               $urandom_range(99) < 28) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= v;
        i_is_last      <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        front = absorb_sample(v, last);
        if (last) begin
            pending_kth.push_back(typed ? want : front);
        end
        samples_sent++;
    endtask

    // sender and sequencing
    initial begin : stimulus
        int          sel;
        t_keep       new_keep;
        int unsigned k_eff;
        int          phase_len;
        int          stream_len;
        int          stream_goal;
        logic        last;
        t_value      value;
        int          drain;

        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_sample_value <= '0;
        i_is_last      <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_data     <= '0;
        keep_reg = 5'd1;
        foreach (kth_store[i]) kth_store[i] = '0;
        stream_len  = 0;
        stream_goal = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].set_keep) begin
                write_keep(directed_rows[r].keep);
            end
            offer(directed_rows[r].value, directed_rows[r].last,
                  directed_rows[r].typed, directed_rows[r].want);
        end

        samples_sent = 0;
        while (samples_sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                new_keep = 5'd0;
            end else if (sel == 1) begin
                new_keep = 5'd16;
            end else if (sel == 2) begin
                new_keep = t_keep'($urandom_range(17, 31));
            end else begin
                new_keep = t_keep'($urandom_range(1, 12));
            end
            write_keep(new_keep);
            k_eff     = live_keep();
            phase_len = $urandom_range(10, 60);
            // a phase may end mid-stream, so k also changes inside a stream
            repeat (phase_len) begin
                if (stream_len == 0) begin
                    stream_goal = $urandom_range(1, 3 * k_eff + 4);
                end
                stream_len++;
                last = (stream_len >= stream_goal);
                if (last) begin
                    stream_len = 0;
                end
                case ($urandom_range(0, 9))
                    0, 1:    value = t_value'($urandom);
                    2, 3, 4: value = t_value'($urandom_range(1, 20));
                    5:       value = -t_value'($urandom_range(0, 1000));
                    6: begin
                        case ($urandom_range(0, 4))
                            0:       value = 32'h7FFF_FFFF;
                            1:       value = 32'h8000_0000;
                            2:       value = 32'h0000_0000;
                            3:       value = 32'h0000_0001;
                            default: value = 32'hFFFF_FFFF;
                        endcase
                    end
                    7:       value = t_value'($urandom_range(1, 1000));
                    default: value = t_value'($urandom & 32'h7FFF_FFFF);
                endcase
                offer(value, last, 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;

        drain = 0;
        while (pending_kth.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        if (pending_kth.size() != 0) begin
            $error("%0d expected results never arrived", pending_kth.size());
            fail_count++;
        end
        repeat (10) @(posedge i_clk);

        $display("%0d random values plus %0d directed rows, %0d results checked",
                 samples_sent, DIRECTED_ROWS, results_checked);
        $display("%0d keep writes incl. zero, 16 and saturating values; one long output hold",
                 keep_writes);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // receiver: checks results and drives output stall
    initial begin : receiver
        int     hold_left;
        logic   hold_done;
        t_value want;

        hold_left = 0;
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (pending_kth.size() == 0) begin
                    $error("unexpected result: kth_largest %0d", o_kth_largest);
                    fail_count++;
                end else begin
                    want = pending_kth.pop_front();
                    if (o_kth_largest !== want) begin
                        $error("kth_largest: expected %0d, actual %0d", want, o_kth_largest);
                        fail_count++;
                    end
                end
                results_checked++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!hold_done && results_checked == 30) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (results_checked >= 60 && results_checked < 85) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < 28);
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
